/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console character writer: shared definitions
// Sizes, character and operation codes, sequencer states, the cell memory
// request and the result record, and the cell address function.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int NUM_SCREENS    = 8;
  localparam int SCREEN_COLUMNS = 80;
  localparam int MAX_ROWS       = 50;
  localparam int CELLS          = NUM_SCREENS * MAX_ROWS * SCREEN_COLUMNS;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int CONS_W = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;

  // Memory address width, and pointer width that can also hold CELLS itself.
  localparam int CELL_AW = $clog2(CELLS);
  localparam int PTR_W   = $clog2(CELLS + 1);
  localparam int SCR_W   = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;

  localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(25);
  localparam logic [ROW_W-1:0] ROWS_MAX   = ROW_W'(MAX_ROWS);
  localparam logic [ROW_W-1:0] ROW_ONE    = ROW_W'(1);
  localparam logic [COL_W-1:0] COLS       = COL_W'(SCREEN_COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [PTR_W-1:0] PTR_COLS   = PTR_W'(SCREEN_COLUMNS);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(CELLS - 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Character codes acted on.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_COPY,
    ST_FILL,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CHAR_W-1:0]  wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] cell_val;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
    logic              ev;
    logic [CHAR_W-1:0] ec;
  } result_t;

  // Linear cell address: screens, then rows, then columns.
  function automatic logic [PTR_W-1:0] cell_addr(input logic [SCR_W-1:0] s,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    int a;
    a = int'(s) * MAX_ROWS * SCREEN_COLUMNS + int'(r) * SCREEN_COLUMNS + int'(c);
    return PTR_W'(a);
  endfunction

endpackage

/* rtl/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// Text console cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
  input  logic                  clk_i,
  input  tcw_pkg::mem_req_t     req_i,
  output logic [tcw_pkg::CHAR_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcw_sequencer.sv */
// ----------------------------------------------------------------------------
// Text console sequencer
// Holds the cursors, decodes each item and drives the cell memory through
// single reads and writes, row copies for scrolling and blank fills.
// ----------------------------------------------------------------------------
module tcw_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tcw_pkg::OP_W-1:0]    op_i,
  input  logic [tcw_pkg::CONS_W-1:0]  console_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  code_i,
  input  logic [tcw_pkg::ROW_W-1:0]   row_i,
  input  logic [tcw_pkg::COL_W-1:0]   col_i,
  input  logic [tcw_pkg::ROW_W-1:0]   rows_i,
  output tcw_pkg::mem_req_t           mem_req_o,
  input  logic [tcw_pkg::CHAR_W-1:0]  rdata_i,
  output tcw_pkg::result_t            res_o,
  input  logic                        res_ready_i
);
  import tcw_pkg::*;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  cur_row_q [NUM_SCREENS];
  logic [ROW_W-1:0]  cur_row_d [NUM_SCREENS];
  logic [COL_W-1:0]  cur_col_q [NUM_SCREENS];
  logic [COL_W-1:0]  cur_col_d [NUM_SCREENS];
  logic [PTR_W-1:0]  ptr_q, ptr_d, end_q, end_d, fbase_q, fbase_d, rda_q, rda_d;
  logic              rdv_q, rdv_d;
  logic [SCR_W-1:0]  cons_q, cons_d;
  logic              ok_q, ok_d, hit_q, hit_d, ev_q, ev_d;
  logic [CHAR_W-1:0] ec_q, ec_d, cell_q, cell_d;

  logic              accept, scr_ok, rd_hit, copy_rd;
  logic [SCR_W-1:0]  s;
  logic [ROW_W-1:0]  rows_m1, f;
  logic [COL_W-1:0]  c;
  logic [PTR_W-1:0]  a_top, a_row1, a_last, a_end, a_read, a_back;

  // Decode of a put.
  logic              p_we, p_ev, p_down;
  logic [PTR_W-1:0]  p_waddr, p_ptr, p_end;
  logic [CHAR_W-1:0] p_wdata, p_ec;
  logic [ROW_W-1:0]  p_row;
  logic [COL_W-1:0]  p_col;
  state_e            p_next;

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign s       = console_i[SCR_W-1:0];
  assign scr_ok  = int'(console_i) < NUM_SCREENS;
  assign rows_m1 = rows_i - ROW_ONE;
  assign f       = (cur_row_q[s] >= rows_i) ? rows_m1 : cur_row_q[s];
  assign c       = cur_col_q[s];
  assign a_top   = cell_addr(s, '0, '0);
  assign a_row1  = cell_addr(s, ROW_ONE, '0);
  assign a_last  = cell_addr(s, rows_m1, '0);
  assign a_end   = cell_addr(s, rows_i, '0);
  assign a_read  = cell_addr(s, row_i, col_i);
  assign a_back  = rda_q - PTR_COLS;
  assign rd_hit  = (row_i < ROWS_MAX) && (col_i < COLS);
  assign copy_rd = (ptr_q != end_q);

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cell_addr(s, f, c);
    p_wdata = CH_SPACE;
    p_ev    = 1'b0;
    p_ec    = CH_NUL;
    p_row   = f;
    p_col   = c;
    p_down  = 1'b0;
    p_next  = ST_RESULT;
    p_ptr   = a_top;
    p_end   = a_end;
    unique case (code_i)
      CH_FF: begin
        p_row  = '0;
        p_col  = '0;
        p_next = ST_FILL;
      end
      CH_CR: begin
        p_col = '0;
      end
      CH_LF: begin
        p_down = 1'b1;
      end
      CH_BS: begin
        if (c != '0) begin
          p_col   = c - 1'b1;
          p_we    = 1'b1;
          p_waddr = cell_addr(s, f, c - 1'b1);
        end else begin
          p_ev = 1'b1;
          p_ec = CH_BEL;
        end
      end
      CH_HT: begin
        p_ev = 1'b1;
        p_ec = CH_SPACE;
      end
      CH_BEL: begin
        p_ev = 1'b1;
        p_ec = CH_BEL;
      end
      default: begin
        p_we    = 1'b1;
        p_wdata = code_i;
        if (c >= COL_LAST) begin
          p_waddr = cell_addr(s, f, COL_LAST);
          p_col   = '0;
          p_down  = 1'b1;
        end else begin
          p_col = c + 1'b1;
        end
      end
    endcase
    if (p_down) begin
      if (f == rows_m1) begin
        // Scroll: copy rows up unless the screen has a single row, then blank
        // the last row.
        if (rows_i == ROW_ONE) begin
          p_next = ST_FILL;
          p_ptr  = a_last;
          p_end  = a_last + PTR_COLS;
        end else begin
          p_next = ST_COPY;
          p_ptr  = a_row1;
          p_end  = a_end;
        end
      end else begin
        p_row = f + 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == PTR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!scr_ok) begin
            state_d = ST_RESULT;
          end else begin
            priority case (op_i)
              OP_PUT:  state_d = p_next;
              OP_READ: state_d = ST_RDWAIT;
              default: state_d = ST_RESULT;
            endcase
          end
        end
      end
      ST_RDWAIT: state_d = ST_RESULT;
      ST_COPY: begin
        if (!copy_rd) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (ptr_q + 1'b1 == end_q) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    fbase_d   = fbase_q;
    rda_d     = rda_q;
    rdv_d     = 1'b0;
    cons_d    = cons_q;
    ok_d      = ok_q;
    hit_d     = hit_q;
    ev_d      = ev_q;
    ec_d      = ec_q;
    cell_d    = cell_q;
    mem_req_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[CELL_AW-1:0];
        mem_req_o.wdata = CH_SPACE;
        ptr_d           = ptr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          cons_d = s;
          ok_d   = scr_ok;
          hit_d  = 1'b0;
          ev_d   = 1'b0;
          ec_d   = CH_NUL;
          cell_d = CH_NUL;
          if (scr_ok) begin
            priority case (op_i)
              OP_PUT: begin
                cur_row_d[s]    = p_row;
                cur_col_d[s]    = p_col;
                mem_req_o.we    = p_we;
                mem_req_o.waddr = p_waddr[CELL_AW-1:0];
                mem_req_o.wdata = p_wdata;
                ev_d            = p_ev;
                ec_d            = p_ec;
                ptr_d           = p_ptr;
                end_d           = p_end;
                fbase_d         = a_last;
              end
              OP_SET: begin
                if ((row_i < rows_i) && (col_i < COLS)) begin
                  cur_row_d[s] = row_i;
                  cur_col_d[s] = col_i;
                end
              end
              OP_READ: begin
                hit_d           = rd_hit;
                mem_req_o.re    = rd_hit;
                mem_req_o.raddr = a_read[CELL_AW-1:0];
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_RDWAIT: begin
        cell_d = hit_q ? rdata_i : CH_NUL;
      end
      ST_COPY: begin
        // Reads run one cell ahead of the writes, which land one row up on the screen.
        mem_req_o.re    = copy_rd;
        mem_req_o.raddr = ptr_q[CELL_AW-1:0];
        rdv_d           = copy_rd;
        rda_d           = ptr_q;
        mem_req_o.we    = rdv_q;
        mem_req_o.waddr = a_back[CELL_AW-1:0];
        mem_req_o.wdata = rdata_i;
        if (copy_rd) begin
          ptr_d = ptr_q + 1'b1;
        end else begin
          ptr_d = fbase_q;
          end_d = fbase_q + PTR_COLS;
        end
      end
      ST_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[CELL_AW-1:0];
        mem_req_o.wdata = CH_SPACE;
        ptr_d           = ptr_q + 1'b1;
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign res_o.valid    = (state_q == ST_RESULT);
  assign res_o.cell_val = cell_q;
  assign res_o.crow     = ok_q ? cur_row_q[cons_q] : '0;
  assign res_o.ccol     = ok_q ? cur_col_q[cons_q] : '0;
  assign res_o.ev       = ev_q;
  assign res_o.ec       = ec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      rdv_q     <= 1'b0;
      cur_row_q <= '{default: '0};
      cur_col_q <= '{default: '0};
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      rdv_q     <= rdv_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    fbase_q <= fbase_d;
    rda_q   <= rda_d;
    cons_q  <= cons_d;
    ok_q    <= ok_d;
    hit_q   <= hit_d;
    ev_q    <= ev_d;
    ec_q    <= ec_d;
    cell_q  <= cell_d;
  end

endmodule

/* rtl/text_console_character_writer.sv */
// ----------------------------------------------------------------------------
// Text console character writer
// Eight 80-column text screens with a cursor each, stored in one cell memory.
// ----------------------------------------------------------------------------
// After reset the block first blanks the whole cell memory, one cell a cycle,
// and stalls its input until that pass is done; a write of the rows register
// is taken during the pass as at any other idle time. Items are then taken
// one at a time, and each gives one result transfer. Setting the cursor,
// carriage return, tab, bell, backspace, and a line feed or printable
// character that does not scroll go from input transfer straight to the
// result state; a cell read first waits for the registered read of the cell
// memory. Form feed blanks all rows in use; a scroll (line feed or wrap on
// the last row) copies the rows up and blanks the last, or only blanks it on
// a single-row screen where there is nothing to copy: the memory has one
// write port, so blanked and moved cells are written one at a time. A
// finished result sits in the output register as the next item is taken in.
// ----------------------------------------------------------------------------
module text_console_character_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ROW_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tcw_pkg::OP_W-1:0]    op_i,
  input  logic [tcw_pkg::CONS_W-1:0]  console_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  code_i,
  input  logic [tcw_pkg::ROW_W-1:0]   row_i,
  input  logic [tcw_pkg::COL_W-1:0]   col_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_value_o,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  output logic                        echo_valid_o,
  output logic [tcw_pkg::CHAR_W-1:0]  echo_code_o
);
  import tcw_pkg::*;

  // Rows register as written; the sequencer sees it clamped to 1..MAX_ROWS.
  logic [ROW_W-1:0]  rows_q, rows_eff;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] rdata;
  result_t           res;
  logic              res_ready;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] cell_q, ec_q;
  logic [ROW_W-1:0]  crow_q;
  logic [COL_W-1:0]  ccol_q;
  logic              ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      rows_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (rows_q == '0) begin
      rows_eff = ROW_ONE;
    end else if (rows_q > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = rows_q;
    end
  end

  tcw_cell_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  tcw_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .console_i   (console_i),
    .code_i      (code_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .rows_i      (rows_eff),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // The output register takes a new result when it is empty or being emptied
  // by a transfer in the same cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      cell_q <= res.cell_val;
      crow_q <= res.crow;
      ccol_q <= res.ccol;
      ev_q   <= res.ev;
      ec_q   <= res.ec;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_q;
  assign cursor_row_o = crow_q;
  assign cursor_col_o = ccol_q;
  assign echo_valid_o = ev_q;
  assign echo_code_o  = ec_q;

endmodule

/* rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// Text console character writer: port checks
// Assertions on the result channel, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tcw_pkg::CHAR_W-1:0]  cell_value_o,
  input logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  input logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  input logic                        echo_valid_o,
  input logic [tcw_pkg::CHAR_W-1:0]  echo_code_o
);
  import tcw_pkg::*;

  // A result waiting under stall stays valid and keeps its cell value, cursor and echo code.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_value_o)
      && $stable(cursor_row_o) && $stable(cursor_col_o) && $stable(echo_code_o))
    else $error("result changed while stalled");

  // The cursor of a valid result lies on the stored screen.
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_row_o < ROWS_MAX) && (cursor_col_o < COLS))
    else $error("cursor outside the screen");

  // Only bell and space go out on the echo channel.
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && echo_valid_o |-> (echo_code_o == CH_BEL) || (echo_code_o == CH_SPACE))
    else $error("unexpected echo code");

  // Without an echo the echo code is zero.
  a_no_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !echo_valid_o |-> echo_code_o == CH_NUL)
    else $error("echo code without echo");

endmodule

bind text_console_character_writer tcw_checker u_tcw_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cell_value_o (cell_value_o),
  .cursor_row_o (cursor_row_o),
  .cursor_col_o (cursor_col_o),
  .echo_valid_o (echo_valid_o),
  .echo_code_o  (echo_code_o)
);

/* sim/text_console_character_writer_tb.sv */
// ----------------------------------------------------------------------------
// Text console character writer: self-checking testbench
// Drives put, set-cursor, read and undefined-operation items at eight text
// screens under several row settings, predicts every result with a
// cycle-free screen model and compares each result transfer field by field,
// with random idling on both sides.
// ----------------------------------------------------------------------------
module text_console_character_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // The fourth operation code is not defined by the block; it must leave
  // every screen alone.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // The longest quiet stretch in a correct run is the clearing pass after
  // reset, over the whole cell memory; a scroll of fifty rows is much
  // shorter. The limit is several times that.
  localparam int WATCHDOG_LIMIT = 150000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int SETTLE_CYCLES  = 10;
  // Above this many rows a scroll or clear is slow, so they are kept rare.
  localparam int TALL_ROWS      = 8;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CONS_W-1:0] console;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } char_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_val;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
    logic              ev;
    logic [CHAR_W-1:0] ec;
  } status_t;

  // Block ports. Every input holds a known value from time zero.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ROW_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   op_i        = OP_PUT;
  logic [CONS_W-1:0] console_i   = '0;
  logic [CHAR_W-1:0] code_i      = '0;
  logic [ROW_W-1:0]  row_i       = '0;
  logic [COL_W-1:0]  col_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHAR_W-1:0] cell_value_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_col_o;
  logic              echo_valid_o;
  logic [CHAR_W-1:0] echo_code_o;

  text_console_character_writer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .console_i    (console_i),
    .code_i       (code_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .echo_valid_o (echo_valid_o),
    .echo_code_o  (echo_code_o)
  );

  // --------------------------------------------------------------------------
  // Screen model: the text of every screen, each cursor and the rows setting.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] screen_text [NUM_SCREENS][MAX_ROWS][SCREEN_COLUMNS];
  logic [ROW_W-1:0]  model_row [NUM_SCREENS];
  logic [COL_W-1:0]  model_col [NUM_SCREENS];
  logic [ROW_W-1:0]  model_rows_reg;

  // Items waiting to be driven, and the status expected from accepted ones.
  char_item_t pending_chars[$];
  status_t    predicted_status_q[$];

  int errors        = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int echoes_seen   = 0;
  int scrolls       = 0;
  int clears        = 0;
  int row_settings  = 0;
  int quiet_cycles  = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int gap_calm      = 0;
  int stall_calm    = 0;
  bit item_taken    = 1'b0;

  // The rows register as the block uses it: zero means one row, and anything
  // above the storage height is clipped to it.
  function automatic int rows_of(input logic [ROW_W-1:0] setting);
    if (setting == '0) return 1;
    if (int'(setting) > MAX_ROWS) return MAX_ROWS;
    return int'(setting);
  endfunction

  // Scroll a screen up by one row and blank the row that comes free.
  function automatic void scroll_screen(input int s, input int rows);
    for (int r = 1; r < rows; r++)
      for (int c = 0; c < SCREEN_COLUMNS; c++)
        screen_text[s][r-1][c] = screen_text[s][r][c];
    for (int c = 0; c < SCREEN_COLUMNS; c++)
      screen_text[s][rows-1][c] = CH_SPACE;
    scrolls++;
  endfunction

  function automatic void line_feed(input int s, input int rows);
    int next_row;
    next_row = int'(model_row[s]) + 1;
    if (next_row >= rows) begin
      scroll_screen(s, rows);
      next_row = rows - 1;
    end
    model_row[s] = ROW_W'(next_row);
  endfunction

  // Apply one accepted item to the model and return the status it must give.
  function automatic status_t advance_screen_model(input char_item_t it);
    status_t res;
    int      s;
    int      rows;
    int      f;
    int      c;
    res  = '0;
    s    = int'(it.console);
    rows = rows_of(model_rows_reg);
    if (s >= NUM_SCREENS) return res;
    case (it.op)
      OP_PUT: begin
        // A cursor left below the screen by a smaller rows setting is pulled
        // up to the last row in use before anything else happens.
        if (int'(model_row[s]) >= rows) model_row[s] = ROW_W'(rows - 1);
        f = int'(model_row[s]);
        c = int'(model_col[s]);
        case (it.code)
          CH_FF: begin
            for (int r = 0; r < rows; r++)
              for (int k = 0; k < SCREEN_COLUMNS; k++)
                screen_text[s][r][k] = CH_SPACE;
            model_row[s] = '0;
            model_col[s] = '0;
            clears++;
          end
          CH_CR: model_col[s] = '0;
          CH_LF: line_feed(s, rows);
          CH_BS: begin
            if (c > 0) begin
              c--;
              screen_text[s][f][c] = CH_SPACE;
              model_col[s] = COL_W'(c);
            end else begin
              res.ev = 1'b1;
              res.ec = CH_BEL;
            end
          end
          CH_HT: begin
            res.ev = 1'b1;
            res.ec = CH_SPACE;
          end
          CH_BEL: begin
            res.ev = 1'b1;
            res.ec = CH_BEL;
          end
          default: begin
            if (c >= SCREEN_COLUMNS) c = SCREEN_COLUMNS - 1;
            screen_text[s][f][c] = it.code;
            c++;
            if (c >= SCREEN_COLUMNS) begin
              model_col[s] = '0;
              line_feed(s, rows);
            end else begin
              model_col[s] = COL_W'(c);
            end
          end
        endcase
      end
      OP_SET: begin
        if (int'(it.row) < rows && int'(it.col) < SCREEN_COLUMNS) begin
          model_row[s] = it.row;
          model_col[s] = it.col;
        end
      end
      OP_READ: begin
        if (int'(it.row) < MAX_ROWS && int'(it.col) < SCREEN_COLUMNS)
          res.cell_val = screen_text[s][it.row][it.col];
      end
      default: ;
    endcase
    res.crow = model_row[s];
    res.ccol = model_col[s];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Idle length for either side: mostly none or short, a few long, and now
  // and then a calm stretch with no idling at all.
  function automatic int pick_idle(ref int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A character to put: mostly printable text, a fair share of control
  // codes, and some arbitrary bytes. On tall screens line feeds and form
  // feeds are mostly turned into carriage returns to keep scrolling cheap.
  function automatic logic [CHAR_W-1:0] pick_put_code(input bit tall);
    logic [CHAR_W-1:0] pick;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      pick = CHAR_W'($urandom_range(8'h21, 8'h7E));
    end else if (roll < 78) begin
      case ($urandom_range(0, 5))
        0:       pick = CH_BEL;
        1:       pick = CH_BS;
        2:       pick = CH_HT;
        3:       pick = CH_LF;
        4:       pick = CH_FF;
        default: pick = CH_CR;
      endcase
    end else begin
      pick = CHAR_W'($urandom_range(0, 255));
    end
    if (tall && (pick == CH_LF || pick == CH_FF) && $urandom_range(0, 9) != 0)
      pick = CH_CR;
    return pick;
  endfunction

  function automatic void push_char(input logic [OP_W-1:0] op, input int console,
                                    input logic [CHAR_W-1:0] code, input int row,
                                    input int col);
    char_item_t it;
    it.op      = op;
    it.console = CONS_W'(console);
    it.code    = code;
    it.row     = ROW_W'(row);
    it.col     = COL_W'(col);
    pending_chars.push_back(it);
  endfunction

  // Random items for the given rows setting. Most of the traffic goes to the
  // first two screens so that text builds up there and reads find it; the
  // fields an operation does not use are left fully random.
  function automatic void add_random_chars(input int count,
                                           input logic [ROW_W-1:0] setting);
    char_item_t it;
    int         rows;
    int         roll;
    rows = rows_of(setting);
    for (int n = 0; n < count; n++) begin
      it.console = ($urandom_range(0, 1) != 0) ? CONS_W'($urandom_range(0, 1))
                                               : CONS_W'($urandom_range(0, 7));
      it.code = CHAR_W'($urandom_range(0, 255));
      it.row  = ROW_W'($urandom_range(0, 63));
      it.col  = COL_W'($urandom_range(0, 127));
      roll    = $urandom_range(0, 99);
      if (roll < 60) begin
        it.op   = OP_PUT;
        it.code = pick_put_code(rows > TALL_ROWS);
      end else if (roll < 95) begin
        it.op = (roll < 75) ? OP_SET : OP_READ;
        // Three in four stay on the screen; the rest may fall off it.
        if ($urandom_range(0, 3) != 0) begin
          it.row = ROW_W'($urandom_range(0, rows - 1));
          it.col = COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
        end
      end else begin
        it.op = OP_NONE;
      end
      pending_chars.push_back(it);
    end
  endfunction

  // The rows register may only change while the block is idle, so callers
  // wait for the pipeline to drain first.
  task automatic write_rows(input logic [ROW_W-1:0] setting);
    @(negedge clk_i);
    cfg_wdata_i <= setting;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    row_settings++;
  endtask

  // Wait until every item has been taken and every result has come back,
  // then give the block time to settle.
  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid_i || predicted_status_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d (result %0d)",
               $realtime, what, got, want, results_seen);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A new item is presented only
  // when the previous one has been transferred or nothing is on offer, so a
  // stalled item never changes. The random gap chosen with an item follows
  // its transfer. The result stall is drawn anew each time a stall run ends.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    char_item_t nxt;
    if (rst_ni && (!in_valid_i || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        nxt        = pending_chars.pop_front();
        op_i       <= nxt.op;
        console_i  <= nxt.console;
        code_i     <= nxt.code;
        row_i      <= nxt.row;
        col_i      <= nxt.col;
        in_valid_i <= 1'b1;
        gap_left   = pick_idle(gap_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (stall_left == 0) stall_left = pick_idle(stall_calm);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge: register writes update
  // the model, an input transfer is run through the model and its status
  // queued, and a result transfer is checked against the oldest expectation.
  // The watchdog ends the run if no transfer happens for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    char_item_t seen;
    status_t    want;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) model_rows_reg = cfg_wdata_i;

      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (predicted_status_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = predicted_status_q.pop_front();
          if (cell_value_o !== want.cell_val)
            report_mismatch("cell value", int'(cell_value_o), int'(want.cell_val));
          if (cursor_row_o !== want.crow)
            report_mismatch("cursor row", int'(cursor_row_o), int'(want.crow));
          if (cursor_col_o !== want.ccol)
            report_mismatch("cursor column", int'(cursor_col_o), int'(want.ccol));
          if (echo_valid_o !== want.ev)
            report_mismatch("echo valid", int'(echo_valid_o), int'(want.ev));
          if (echo_code_o !== want.ec)
            report_mismatch("echo code", int'(echo_code_o), int'(want.ec));
          if (want.ev) echoes_seen++;
        end
        results_seen++;
      end

      if (in_valid_i && !in_stall_o) begin
        moved        = 1'b1;
        item_taken   = 1'b1;
        seen.op      = op_i;
        seen.console = console_i;
        seen.code    = code_i;
        seen.row     = row_i;
        seen.col     = col_i;
        predicted_status_q.push_back(advance_screen_model(seen));
        items_taken++;
      end

      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, predicted_status_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    for (int s = 0; s < NUM_SCREENS; s++) begin
      model_row[s] = '0;
      model_col[s] = '0;
      for (int r = 0; r < MAX_ROWS; r++)
        for (int c = 0; c < SCREEN_COLUMNS; c++)
          screen_text[s][r][c] = CH_SPACE;
    end
    model_rows_reg = ROWS_RESET;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on a three-row screen, so that scrolling is cheap. The
    // register write lands during the clearing pass, which is allowed.
    write_rows(ROW_W'(3));
    push_char(OP_PUT,  0, 8'h41, 0, 0);
    push_char(OP_PUT,  0, 8'hFF, 63, 127);     // top byte value is printable
    push_char(OP_PUT,  0, CH_NUL, 0, 0);       // so is the zero byte
    push_char(OP_READ, 0, 8'h00, 0, 0);
    push_char(OP_READ, 0, 8'h00, 0, 1);
    push_char(OP_PUT,  0, CH_BS, 0, 0);        // erase the zero byte
    push_char(OP_READ, 0, 8'h00, 0, 2);
    push_char(OP_PUT,  0, CH_CR, 0, 0);
    push_char(OP_PUT,  0, CH_BS, 0, 0);        // backspace at column 0 rings
    push_char(OP_PUT,  0, CH_HT, 0, 0);
    push_char(OP_PUT,  0, CH_BEL, 0, 0);
    push_char(OP_PUT,  0, CH_LF, 0, 0);
    push_char(OP_PUT,  0, CH_LF, 0, 0);
    push_char(OP_PUT,  0, CH_LF, 0, 0);        // scrolls the top line away
    push_char(OP_SET,  0, 8'h00, 2, 79);
    push_char(OP_PUT,  0, 8'h7E, 0, 0);        // wrap on the last row scrolls
    push_char(OP_READ, 0, 8'h00, 1, 79);
    push_char(OP_SET,  0, 8'h00, 63, 127);     // off the screen: ignored
    push_char(OP_SET,  0, 8'h00, 3, 0);        // first row past the screen
    push_char(OP_SET,  0, 8'h00, 0, 80);       // first column past the screen
    push_char(OP_READ, 0, 8'h00, 63, 127);     // outside storage reads zero
    push_char(OP_READ, 0, 8'h00, 49, 79);      // past the screen, in storage
    push_char(OP_NONE, 3, 8'hFF, 63, 127);
    push_char(OP_PUT,  7, 8'h5A, 63, 127);
    push_char(OP_PUT,  0, CH_FF, 0, 0);
    push_char(OP_READ, 0, 8'h00, 1, 79);
    wait_drained();

    // Reset height. Park a cursor on the last row for the shrink case below.
    write_rows(ROWS_RESET);
    push_char(OP_SET, 5, 8'h00, 24, 5);
    add_random_chars(40, ROWS_RESET);
    wait_drained();

    // Two rows: the parked cursor is now below the screen and is pulled up
    // by the next put.
    write_rows(ROW_W'(2));
    push_char(OP_PUT, 5, 8'h51, 0, 0);
    add_random_chars(90, ROW_W'(2));
    wait_drained();

    // Zero behaves as a single row.
    write_rows('0);
    add_random_chars(70, '0);
    wait_drained();

    write_rows(ROW_ONE);
    add_random_chars(70, ROW_ONE);
    wait_drained();

    // All ones is clipped to the full height; one full-height scroll.
    write_rows('1);
    push_char(OP_SET, 2, 8'h00, MAX_ROWS - 1, SCREEN_COLUMNS - 1);
    push_char(OP_PUT, 2, 8'h21, 0, 0);
    add_random_chars(40, '1);
    wait_drained();

    write_rows(ROWS_MAX);
    add_random_chars(30, ROWS_MAX);
    wait_drained();

    write_rows(ROW_W'(7));
    add_random_chars(100, ROW_W'(7));
    wait_drained();

    write_rows(ROW_W'(5));
    add_random_chars(60, ROW_W'(5));
    wait_drained();

    $display("Run covered %0d items under %0d rows settings; %0d results checked.",
             items_taken, row_settings, results_seen);
    $display("Model saw %0d scrolls, %0d screen clears and %0d echoes.",
             scrolls, clears, echoes_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_sequencer.sv
rtl/text_console_character_writer.sv
rtl/tcw_checker.sv
sim/text_console_character_writer_tb.sv
